// ===== hw/rtl/deq_pkg.sv =====
// shared types and constants for the double-ended queue core
// action, status and datapath operation codes, controller/datapath structs
// no dependencies
package deq_pkg;

  localparam int DEQ_DEPTH = 64;
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 3;
  localparam int OP_W      = 4;

  // input actions
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST       = 3'd4;

  // result status
  localparam logic [STAT_W-1:0] ST_PUSHED = 3'd0;
  localparam logic [STAT_W-1:0] ST_POPPED = 3'd1;
  localparam logic [STAT_W-1:0] ST_LISTED = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

  // datapath operations issued by the controller
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd4;
  localparam logic [OP_W-1:0] OP_LIST_FIRST = 4'd5;
  localparam logic [OP_W-1:0] OP_LIST_NEXT  = 4'd6;
  localparam logic [OP_W-1:0] OP_REP_EMPTY  = 4'd7;
  localparam logic [OP_W-1:0] OP_REP_FULL   = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } deq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
    logic list_end;
  } deq_stat_t;

endpackage

// ===== hw/rtl/double_ended_queue_core.sv =====
// top level of the double-ended queue core
// channel   | handshake               | payload
// command   | start_i, busy_o         | action_i, value_i
// result    | out_valid_o (strobe)    | status_o, result_value_o, last_o
//
// push, pop and reported empty/full: the result strobe follows the command
// transfer in the next cycle and busy_o stays low
// listing reads each entry once from the ram, with busy_o high for all but the first read
// reset clears the front pointer, count and list counter at once; the entry ram is not cleared
// results cannot be held off: each is presented for exactly one cycle
// depends on deq_pkg, deq_ctrl, deq_dp
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic                     last_o
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_i        (value_i),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .last_o         (last_o)
  );

endmodule

// ===== hw/rtl/deq_ram.sv =====
// generic single-port ram with registered read
// no reset on the array or the read data
// no dependencies
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// controller for the double-ended queue core
// decodes actions into datapath operations and sequences listing
// depends on deq_pkg
module deq_ctrl
  import deq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACT_W-1:0] action_i,
  input  deq_stat_t        stat_i,
  output deq_cmd_t         cmd_o,
  output logic             busy_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (action_i)
            ACT_PUSH_FRONT: cmd_o.op = stat_i.full ? OP_REP_FULL : OP_PUSH_FRONT;
            ACT_PUSH_BACK:  cmd_o.op = stat_i.full ? OP_REP_FULL : OP_PUSH_BACK;
            ACT_POP_FRONT:  cmd_o.op = stat_i.empty ? OP_REP_EMPTY : OP_POP_FRONT;
            ACT_POP_BACK:   cmd_o.op = stat_i.empty ? OP_REP_EMPTY : OP_POP_BACK;
            ACT_LIST: begin
              if (stat_i.empty) begin
                cmd_o.op = OP_REP_EMPTY;
              end else begin
                cmd_o.op = OP_LIST_FIRST;
                // a single entry is done by the first list read alone
                if (!stat_i.one_left) begin
                  state_d = S_LIST;
                end
              end
            end
            default: cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_LIST: begin
        cmd_o.op = OP_LIST_NEXT;
        if (stat_i.list_end) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == S_LIST);

endmodule

// ===== hw/rtl/deq_dp.sv =====
// datapath for the double-ended queue core
// front ring pointer, entry count, list counter, entry ram and result registers
// depends on deq_pkg and deq_ram
module deq_dp
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  deq_cmd_t                 cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  output deq_stat_t                stat_o,
  output logic                     out_valid_o,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic                     last_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  list_q, list_d;
  logic              valid_q, valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              last_q, last_d;
  logic              sel_q, sel_d;

  logic [CNT_W-1:0]  offset;
  logic [IDX_W:0]    slot_sum;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  front_inc;
  logic [IDX_W-1:0]  ram_addr;
  logic              ram_we;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CNT_W'(DEPTH));
  assign stat_o.one_left = (count_q == CNT_W'(1));
  assign stat_o.list_end = (list_q == CNT_W'(1));

  assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

  // ring slot at an offset from the front; offset is below depth whenever the slot is used
  always_comb begin
    case (cmd_i.op)
      OP_PUSH_BACK: offset = count_q;
      OP_LIST_NEXT: offset = list_q - 1'b1;
      OP_POP_FRONT: offset = '0;
      default:      offset = count_q - 1'b1;
    endcase
    slot_sum = {1'b0, front_q} + {1'b0, offset[IDX_W-1:0]};
    if (slot_sum >= (IDX_W+1)'(DEPTH)) begin
      slot = IDX_W'(slot_sum - (IDX_W+1)'(DEPTH));
    end else begin
      slot = slot_sum[IDX_W-1:0];
    end
  end

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    list_d   = list_q;
    valid_d  = 1'b1;
    status_d = status_q;
    last_d   = 1'b1;
    sel_d    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = slot;
    case (cmd_i.op)
      OP_PUSH_FRONT: begin
        ram_we   = 1'b1;
        ram_addr = front_dec;
        front_d  = front_dec;
        count_d  = count_q + 1'b1;
        status_d = ST_PUSHED;
      end
      OP_PUSH_BACK: begin
        ram_we   = 1'b1;
        count_d  = count_q + 1'b1;
        status_d = ST_PUSHED;
      end
      OP_POP_FRONT: begin
        ram_re   = 1'b1;
        front_d  = front_inc;
        count_d  = count_q - 1'b1;
        status_d = ST_POPPED;
        sel_d    = 1'b1;
      end
      OP_POP_BACK: begin
        ram_re   = 1'b1;
        count_d  = count_q - 1'b1;
        status_d = ST_POPPED;
        sel_d    = 1'b1;
      end
      OP_LIST_FIRST: begin
        ram_re   = 1'b1;
        list_d   = count_q - 1'b1;
        status_d = ST_LISTED;
        last_d   = stat_o.one_left;
        sel_d    = 1'b1;
      end
      OP_LIST_NEXT: begin
        ram_re   = 1'b1;
        list_d   = list_q - 1'b1;
        status_d = ST_LISTED;
        last_d   = stat_o.list_end;
        sel_d    = 1'b1;
      end
      OP_REP_EMPTY: status_d = ST_EMPTY;
      OP_REP_FULL:  status_d = ST_FULL;
      default: begin
        valid_d = 1'b0;
        last_d  = last_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      list_q   <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_PUSHED;
      last_q   <= 1'b0;
      sel_q    <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      list_q   <= list_d;
      valid_q  <= valid_d;
      status_q <= status_d;
      last_q   <= last_d;
      sel_q    <= sel_d;
    end
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (value_i),
    .rdata_o (ram_rdata)
  );

  // read data lands in the ram output register in the same cycle as the strobe
  assign out_valid_o    = valid_q;
  assign status_o       = status_q;
  assign last_o         = last_q;
  assign result_value_o = sel_q ? $signed(ram_rdata) : '0;

endmodule
